// ===== hw/rtl/bfp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants of the bootloader frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package bfp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam kind_t KIND_NONE    = 2'd0;
	localparam kind_t KIND_PAYLOAD = 2'd1;
	localparam kind_t KIND_DONE    = 2'd2;

	localparam cfg_idx_t CFG_HEAD      = 2'd0;
	localparam cfg_idx_t CFG_TAIL      = 2'd1;
	localparam cfg_idx_t CFG_SLAVE     = 2'd2;
	localparam cfg_idx_t CFG_MAX_CMD   = 2'd3;

	localparam byte_t HEAD_RST    = 8'h00;
	localparam byte_t TAIL_RST    = 8'h00;
	localparam byte_t SLAVE_RST   = 8'h00;
	localparam byte_t MAX_CMD_RST = 8'h04;

	localparam byte_t CHECK_BYTE   = 8'hFF;
	localparam byte_t LEN_OVERHEAD = 8'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/bfp_if.sv =====
// ----------------------------------------------------------------------------
// bfp_rx_if / bfp_res_if
// Valid/ready channels: received bytes in, parser results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfp_rx_if;
	logic          valid;
	logic          ready;
	bfp_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfp_res_if;
	logic           valid;
	logic           ready;
	bfp_pkg::kind_t kind;
	bfp_pkg::byte_t data_byte;
	bfp_pkg::byte_t byte_index;
	bfp_pkg::byte_t command;
	bfp_pkg::byte_t payload_len;

	modport source (output valid, output kind, output data_byte, output byte_index,
		output command, output payload_len, input ready);
	modport sink   (input valid, input kind, input data_byte, input byte_index,
		input command, input payload_len, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bootloader_frame_parser.sv =====
// ----------------------------------------------------------------------------
// bootloader_frame_parser
// Byte-serial recognizer of bootloader frames with streamed payload.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and returns exactly one result per byte:
// nothing, a payload byte with its index, or a frame-complete report with
// command and payload length. The byte is captured in the input stage, and
// the frame state and result register update from it as it moves on to the
// result stage. Throughput is one byte per cycle while the result side takes
// a result per cycle; rx.ready drops only while both stages hold unread data.
// Configuration writes are expected only while the parser is idle.
`default_nettype none

module bootloader_frame_parser (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  bfp_pkg::cfg_idx_t      cfg_index,
	input  bfp_pkg::byte_t         cfg_data,
	bfp_rx_if.sink                 rx,
	bfp_res_if.source              res
);

	localparam logic [2:0] PH_HEAD   = 3'd0;
	localparam logic [2:0] PH_ADDR   = 3'd1;
	localparam logic [2:0] PH_CMD    = 3'd2;
	localparam logic [2:0] PH_LEN    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CHK_HI = 3'd5;
	localparam logic [2:0] PH_CHK_LO = 3'd6;
	localparam logic [2:0] PH_TAIL   = 3'd7;

	bfp_pkg::byte_t head_q, tail_q, slave_q, max_cmd_q;

	logic           v_s1;
	bfp_pkg::byte_t byte_s1;
	logic           v_s2;
	logic           adv_s2;
	logic           adv_s1;

	logic [2:0]     phase_q, phase_d;
	bfp_pkg::byte_t remaining_q, remaining_d;
	bfp_pkg::byte_t count_q, count_d;
	bfp_pkg::byte_t cmd_q, cmd_d;

	bfp_pkg::kind_t kind_d, kind_s2;
	bfp_pkg::byte_t data_d, data_s2;
	bfp_pkg::byte_t idx_d, idx_s2;
	bfp_pkg::byte_t rcmd_d, rcmd_s2;
	bfp_pkg::byte_t plen_d, plen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= bfp_pkg::HEAD_RST;
			tail_q    <= bfp_pkg::TAIL_RST;
			slave_q   <= bfp_pkg::SLAVE_RST;
			max_cmd_q <= bfp_pkg::MAX_CMD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfp_pkg::CFG_HEAD:    head_q    <= cfg_data;
				bfp_pkg::CFG_TAIL:    tail_q    <= cfg_data;
				bfp_pkg::CFG_SLAVE:   slave_q   <= cfg_data;
				bfp_pkg::CFG_MAX_CMD: max_cmd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s2   = !v_s2 || res.ready;
	assign adv_s1   = v_s1 && adv_s2;
	assign rx.ready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		count_d     = count_q;
		cmd_d       = cmd_q;
		kind_d      = bfp_pkg::KIND_NONE;
		data_d      = '0;
		idx_d       = '0;
		rcmd_d      = '0;
		plen_d      = '0;
		unique case (phase_q)
			PH_HEAD: begin
				count_d = '0;
				if (byte_s1 == head_q) phase_d = PH_ADDR;
			end
			PH_ADDR: phase_d = (byte_s1 == slave_q) ? PH_CMD : PH_HEAD;
			PH_CMD: begin
				if (byte_s1 <= max_cmd_q) begin
					cmd_d   = byte_s1;
					phase_d = PH_LEN;
				end else begin
					phase_d = PH_HEAD;
				end
			end
			PH_LEN: begin
				remaining_d = byte_s1 - bfp_pkg::LEN_OVERHEAD;
				count_d     = '0;
				phase_d     = (remaining_d != '0) ? PH_DATA : PH_CHK_HI;
			end
			PH_DATA: begin
				if (remaining_q != '0) begin
					kind_d      = bfp_pkg::KIND_PAYLOAD;
					data_d      = byte_s1;
					idx_d       = count_q;
					count_d     = count_q + 8'd1;
					remaining_d = remaining_q - 8'd1;
				end
				if (remaining_d == '0) phase_d = PH_CHK_HI;
			end
			PH_CHK_HI: phase_d = (byte_s1 == bfp_pkg::CHECK_BYTE) ? PH_CHK_LO : PH_HEAD;
			PH_CHK_LO: phase_d = (byte_s1 == bfp_pkg::CHECK_BYTE) ? PH_TAIL : PH_HEAD;
			PH_TAIL: begin
				if (byte_s1 == tail_q) begin
					kind_d = bfp_pkg::KIND_DONE;
					rcmd_d = cmd_q;
					plen_d = count_q;
				end
				phase_d = PH_HEAD;
			end
			default: phase_d = PH_HEAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEAD;
			remaining_q <= '0;
			count_q     <= '0;
			cmd_q       <= '0;
			v_s2        <= 1'b0;
		end else begin
			if (adv_s1) begin
				phase_q     <= phase_d;
				remaining_q <= remaining_d;
				count_q     <= count_d;
				cmd_q       <= cmd_d;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s2 <= kind_d;
			data_s2 <= data_d;
			idx_s2  <= idx_d;
			rcmd_s2 <= rcmd_d;
			plen_s2 <= plen_d;
		end
	end

	assign res.valid       = v_s2;
	assign res.kind        = kind_s2;
	assign res.data_byte   = data_s2;
	assign res.byte_index  = idx_s2;
	assign res.command     = rcmd_s2;
	assign res.payload_len = plen_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/bfp_checker.sv =====
// ----------------------------------------------------------------------------
// bfp_checker
// Port-level checks of the frame parser, bound to bootloader_frame_parser.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            res_valid,
	input wire            res_ready,
	input bfp_pkg::kind_t kind,
	input bfp_pkg::byte_t data_byte,
	input bfp_pkg::byte_t byte_index,
	input bfp_pkg::byte_t command,
	input bfp_pkg::byte_t payload_len
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(data_byte)
			&& $stable(byte_index) && $stable(command) && $stable(payload_len))
		else $error("result changed while stalled");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> kind == bfp_pkg::KIND_NONE || kind == bfp_pkg::KIND_PAYLOAD
			|| kind == bfp_pkg::KIND_DONE)
		else $error("undefined result kind");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == bfp_pkg::KIND_NONE |-> data_byte == '0 && byte_index == '0
			&& command == '0 && payload_len == '0)
		else $error("empty result carries data");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == bfp_pkg::KIND_PAYLOAD |-> command == '0 && payload_len == '0
			&& byte_index != 8'hFF)
		else $error("payload result with frame fields or bad index");

endmodule

bind bootloader_frame_parser bfp_checker u_bfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.kind        (res.kind),
	.data_byte   (res.data_byte),
	.byte_index  (res.byte_index),
	.command     (res.command),
	.payload_len (res.payload_len)
);

`default_nettype wire

// ===== verif/bfp_result_checker.sv =====
// ----------------------------------------------------------------------------
// bfp_result_checker
// Watches the byte and result channels of the frame parser, keeps its own
// frame-recognition state and register copy, and compares every result
// transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bfp_result_checker (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  bfp_pkg::cfg_idx_t  cfg_index,
	input  bfp_pkg::byte_t     cfg_data,
	bfp_rx_if                  rx,
	bfp_res_if                 res,
	output int unsigned        errors,
	output int unsigned        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		P_HUNT, P_ADDR, P_CMD, P_LEN, P_DATA, P_CHK_HI, P_CHK_LO, P_TAIL
	} parse_phase_t;

	typedef struct packed {
		bfp_pkg::kind_t kind;
		bfp_pkg::byte_t data_byte;
		bfp_pkg::byte_t byte_index;
		bfp_pkg::byte_t command;
		bfp_pkg::byte_t payload_len;
	} parse_res_t;

	bfp_pkg::byte_t head_q, tail_q, slave_q, maxcmd_q;
	parse_phase_t ph;
	bfp_pkg::byte_t left_cnt, seen_cnt, cur_cmd;
	parse_res_t want_q[$];

	function automatic parse_res_t parse_byte(bfp_pkg::byte_t b);
		parse_res_t r;
		r = '0;
		case (ph)
		P_HUNT: begin
			seen_cnt = '0;
			if (b == head_q)
				ph = P_ADDR;
		end
		P_ADDR: ph = (b == slave_q) ? P_CMD : P_HUNT;
		P_CMD: begin
			if (b <= maxcmd_q) begin
				cur_cmd = b;
				ph = P_LEN;
			end else begin
				ph = P_HUNT;
			end
		end
		P_LEN: begin
			left_cnt = b - bfp_pkg::LEN_OVERHEAD;
			seen_cnt = '0;
			ph = (left_cnt != 0) ? P_DATA : P_CHK_HI;
		end
		P_DATA: begin
			if (left_cnt != 0) begin
				r.kind = bfp_pkg::KIND_PAYLOAD;
				r.data_byte = b;
				r.byte_index = seen_cnt;
				seen_cnt = seen_cnt + 8'd1;
				left_cnt = left_cnt - 8'd1;
			end
			if (left_cnt == 0)
				ph = P_CHK_HI;
		end
		P_CHK_HI: ph = (b == bfp_pkg::CHECK_BYTE) ? P_CHK_LO : P_HUNT;
		P_CHK_LO: ph = (b == bfp_pkg::CHECK_BYTE) ? P_TAIL : P_HUNT;
		default: begin
			if (b == tail_q) begin
				r.kind = bfp_pkg::KIND_DONE;
				r.command = cur_cmd;
				r.payload_len = seen_cnt;
			end
			ph = P_HUNT;
		end
		endcase
		return r;
	endfunction

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, seen);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		parse_res_t want;
		if (!arst_n) begin
			head_q = bfp_pkg::HEAD_RST;
			tail_q = bfp_pkg::TAIL_RST;
			slave_q = bfp_pkg::SLAVE_RST;
			maxcmd_q = bfp_pkg::MAX_CMD_RST;
			ph = P_HUNT;
			left_cnt = '0;
			seen_cnt = '0;
			cur_cmd = '0;
			want_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				bfp_pkg::CFG_HEAD:    head_q = cfg_data;
				bfp_pkg::CFG_TAIL:    tail_q = cfg_data;
				bfp_pkg::CFG_SLAVE:   slave_q = cfg_data;
				bfp_pkg::CFG_MAX_CMD: maxcmd_q = cfg_data;
				default: ;
				endcase
			end
			if (rx.valid && rx.ready)
				want_q.push_back(parse_byte(rx.rx_byte));
			if (res.valid && res.ready) begin
				if (want_q.size() == 0) begin
					$display("%0t: unexpected result transfer, expected none actual kind %0d",
						$time, res.kind);
					errors++;
				end else begin
					want = want_q.pop_front();
					check_field("kind", want.kind, res.kind);
					check_field("data_byte", want.data_byte, res.data_byte);
					check_field("byte_index", want.byte_index, res.byte_index);
					check_field("command", want.command, res.command);
					check_field("payload_len", want.payload_len, res.payload_len);
				end
			end
			pending = want_q.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bootloader frame parser: directed frames,
// a back-pressure stretch, then random frames with noise and corruption
// under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NO_BREAK = -1;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_BYTES = 150;
	localparam int unsigned CYCLE_LIMIT = 100000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	bfp_pkg::cfg_idx_t cfg_index;
	bfp_pkg::byte_t cfg_data;

	bfp_rx_if rx_ch ();
	bfp_res_if res_ch ();

	int unsigned err_cnt;
	int unsigned pending_cnt;
	int unsigned cycles;
	int snd_idle;
	int rcv_idle;
	bit hold_req;
	logic rx_took;
	bfp_pkg::byte_t head_v, tail_v, slave_v, maxc_v;

	bootloader_frame_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	bfp_result_checker checker_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.res       (res_ch),
		.errors    (err_cnt),
		.pending   (pending_cnt)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial rx_took = 1'b0;
	always @(posedge clk)
		rx_took <= rx_ch.valid && rx_ch.ready;

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_byte(input bfp_pkg::byte_t b);
		while ($urandom_range(99) < snd_idle) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(negedge clk); while (!rx_took);
	endtask

	task automatic pause_input();
		rx_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_cnt != 0);
	endtask

	task automatic write_regs(input bfp_pkg::byte_t h, input bfp_pkg::byte_t t,
			input bfp_pkg::byte_t s, input bfp_pkg::byte_t m);
		cfg_we <= 1'b1;
		cfg_index <= bfp_pkg::CFG_HEAD;
		cfg_data <= h;
		@(negedge clk);
		cfg_index <= bfp_pkg::CFG_TAIL;
		cfg_data <= t;
		@(negedge clk);
		cfg_index <= bfp_pkg::CFG_SLAVE;
		cfg_data <= s;
		@(negedge clk);
		cfg_index <= bfp_pkg::CFG_MAX_CMD;
		cfg_data <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		head_v = h;
		tail_v = t;
		slave_v = s;
		maxc_v = m;
	endtask

	function automatic bfp_pkg::byte_t pick_payload();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return head_v;
		if (r < 30)
			return tail_v;
		return bfp_pkg::byte_t'($urandom_range(255));
	endfunction

	// brk_at flips the byte at that frame position to a different value
	task automatic send_frame(input bfp_pkg::byte_t addr, input bfp_pkg::byte_t cmd,
			input bfp_pkg::byte_t len, input int brk_at, output int n_sent);
		bfp_pkg::byte_t fr[$];
		bfp_pkg::byte_t npay;
		npay = len - bfp_pkg::LEN_OVERHEAD;
		fr.push_back(head_v);
		fr.push_back(addr);
		fr.push_back(cmd);
		fr.push_back(len);
		repeat (npay) fr.push_back(pick_payload());
		fr.push_back(bfp_pkg::CHECK_BYTE);
		fr.push_back(bfp_pkg::CHECK_BYTE);
		fr.push_back(tail_v);
		if (brk_at >= 0 && brk_at < fr.size())
			fr[brk_at] = fr[brk_at] ^ bfp_pkg::byte_t'($urandom_range(255, 1));
		foreach (fr[i])
			send_byte(fr[i]);
		n_sent = fr.size();
	endtask

	task automatic random_frame(output int n_sent);
		bfp_pkg::byte_t cmd, len, addr, npay;
		int r, brk;
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(3, 1)) send_byte(bfp_pkg::byte_t'($urandom_range(255)));
		addr = ($urandom_range(99) < 90) ? slave_v : bfp_pkg::byte_t'($urandom_range(255));
		cmd = ($urandom_range(99) < 85) ? bfp_pkg::byte_t'($urandom_range(maxc_v))
			: bfp_pkg::byte_t'($urandom_range(255));
		len = ($urandom_range(99) < 80) ? bfp_pkg::byte_t'($urandom_range(10, 3))
			: bfp_pkg::byte_t'($urandom_range(40, 3));
		npay = len - bfp_pkg::LEN_OVERHEAD;
		brk = NO_BREAK;
		if ($urandom_range(99) < 25) begin
			r = $urandom_range(6);
			brk = (r < 4) ? r : int'(npay) + r;
		end
		send_frame(addr, cmd, len, brk, n_sent);
	endtask

	initial begin
		int n;
		int budget;
		bit wrap_sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bfp_pkg::CFG_HEAD;
		cfg_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		hold_req = 1'b0;
		snd_idle = 0;
		rcv_idle = 0;
		head_v = bfp_pkg::HEAD_RST;
		tail_v = bfp_pkg::TAIL_RST;
		slave_v = bfp_pkg::SLAVE_RST;
		maxc_v = bfp_pkg::MAX_CMD_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values
		send_frame(slave_v, maxc_v, bfp_pkg::LEN_OVERHEAD, NO_BREAK, n);
		send_frame(slave_v, 8'd0, 8'd5, NO_BREAK, n);
		send_frame(slave_v, 8'd1, bfp_pkg::LEN_OVERHEAD, 1, n);        // wrong address
		send_frame(slave_v, maxc_v + 8'd1, bfp_pkg::LEN_OVERHEAD, NO_BREAK, n);
		send_frame(slave_v, 8'd2, bfp_pkg::LEN_OVERHEAD, 5, n);        // wrong second check byte
		send_frame(slave_v, 8'd3, bfp_pkg::LEN_OVERHEAD, 6, n);        // wrong tail
		pause_input();

		// back-pressure: result side held off while bytes keep coming
		write_regs(8'hFF, 8'h00, 8'hFF, 8'h00);
		hold_req = 1'b1;
		repeat (6) random_frame(n);
		pause_input();

		for (int p = 0; p < 3; p++) begin
			case (p)
			0: begin
				snd_idle = 37;
				rcv_idle = 45;
				write_regs(bfp_pkg::byte_t'($urandom_range(255)),
					bfp_pkg::byte_t'($urandom_range(255)),
					bfp_pkg::byte_t'($urandom_range(255)),
					bfp_pkg::byte_t'($urandom_range(255)));
			end
			1: begin
				snd_idle = 45;
				rcv_idle = 37;
				write_regs(8'h00, 8'hFF, 8'h00, 8'hFF);
			end
			default: begin
				snd_idle = 0;
				rcv_idle = 0;
				write_regs(bfp_pkg::byte_t'($urandom_range(255)),
					bfp_pkg::byte_t'($urandom_range(255)),
					bfp_pkg::byte_t'($urandom_range(255)),
					bfp_pkg::byte_t'($urandom_range(255)));
			end
			endcase
			budget = PHASE_BYTES;
			wrap_sent = (p != 1);
			while (budget > 0) begin
				if (!wrap_sent && $urandom_range(9) == 0) begin
					// length below the overhead wraps to a long payload
					send_frame(slave_v, bfp_pkg::byte_t'($urandom_range(maxc_v)),
						bfp_pkg::byte_t'($urandom_range(2)), NO_BREAK, n);
					wrap_sent = 1'b1;
				end else begin
					random_frame(n);
				end
				budget -= n;
			end
			if (!wrap_sent)
				send_frame(slave_v, bfp_pkg::byte_t'($urandom_range(maxc_v)),
					bfp_pkg::byte_t'($urandom_range(2)), NO_BREAK, n);
			pause_input();
		end

		repeat (4) @(negedge clk);
		if (err_cnt == 0 && pending_cnt == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
